/* rtl/lcs_pkg.sv */
// lcs_pkg: shared widths, constants and codes of the luma contrast stretch block
// used by the channel interfaces and by luma_contrast_stretch_unit
`timescale 1ns / 1ps

package lcs_pkg;

   localparam int PIXEL_W    = 24;
   localparam int CHAN_W     = 8;
   localparam int PCT_W      = 10;
   localparam int LUMA_W     = 8;
   localparam int SUM_W      = 15;  // r*11 + g*80 + b*9 <= 25500
   localparam int NUM_W      = 18;  // (upper - lower) * luma <= 260865
   localparam int PCT_EXT_W  = 20;  // signed percentage before clamping
   localparam int PCT_SAT_W  = 15;
   localparam int PROD_W     = 23;  // channel * clamped percentage
   localparam int RECIP_W    = 13;
   localparam int RECIP_SH   = 19;
   localparam int MULT_W     = 28;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int DIV_STEPS  = 9;   // two quotient bits per step
   localparam int DIV_CNT_W  = 4;

   localparam logic [SUM_W-1:0]     R_WEIGHT       = 15'd11;
   localparam logic [SUM_W-1:0]     G_WEIGHT       = 15'd80;
   localparam logic [SUM_W-1:0]     B_WEIGHT       = 15'd9;
   // x / 100 == (x * 5243) >> 19 for every x below 43699
   localparam logic [RECIP_W-1:0]   DIV100_RECIP   = 13'd5243;
   localparam logic [LUMA_W-1:0]    MIN_LUMA_RESET = 8'd100;
   localparam logic [LUMA_W-1:0]    MAX_LUMA_RESET = 8'd0;
   localparam logic [PCT_W-1:0]     LOWER_RESET    = 10'd0;
   localparam logic [PCT_W-1:0]     UPPER_RESET    = 10'd100;
   // any percentage at or above 25600 saturates every nonzero channel
   localparam logic [PCT_SAT_W-1:0] PCT_SAT        = 15'd25600;
   localparam logic [PROD_W-1:0]    PROD_SAT       = 23'd25600;
   localparam logic [CHAN_W-1:0]    CHAN_MAX       = 8'd255;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST       = 4'(DIV_STEPS - 1);

   typedef enum logic {
      CMD_MEASURE = 1'b0,
      CMD_REMAP   = 1'b1
   } cmd_type;

   typedef enum logic {
      REG_LOWER = 1'b0,
      REG_UPPER = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      CH_RED   = 2'd0,
      CH_GREEN = 2'd1,
      CH_BLUE  = 2'd2
   } chan_sel_type;

endpackage

/* rtl/lcs_channels.sv */
// lcs_req_if / lcs_rsp_if: valid-ready channels of the luma contrast stretch block
// depends on lcs_pkg for the payload widths
`timescale 1ns / 1ps

interface lcs_req_if;
   import lcs_pkg::*;

   logic               valid;
   logic               ready;
   logic               cmd;
   logic               first_pixel;
   logic [PIXEL_W-1:0] pixel_rgb;

   modport source (output valid, output cmd, output first_pixel, output pixel_rgb,
                   input ready);
   modport sink (input valid, input cmd, input first_pixel, input pixel_rgb,
                 output ready);
endinterface

interface lcs_rsp_if;
   import lcs_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] out_rgb;

   modport source (output valid, output out_rgb, input ready);
   modport sink (input valid, input out_rgb, output ready);
endinterface

/* rtl/luma_contrast_stretch_unit.sv */
// luma_contrast_stretch_unit: two-pass luminance contrast stretch on packed rgb pixels
// depends on lcs_pkg and the channel interfaces in lcs_channels.sv
`timescale 1ns / 1ps

// usage:
//  req_chan carries cmd, first_pixel and pixel_rgb. a measure transfer (cmd 0) folds
//  the pixel's luminance into the stored minimum and maximum, first_pixel restarting
//  them at 100 and 0; it gives no response. a remap transfer (cmd 1) gives exactly
//  one response on rsp_chan with the rescaled pixel in out_rgb.
//  lower_percent (addr 0) and upper_percent (addr 4) are written over the apb port
//  by the user only while the block is idle; the block itself does not enforce this.
//  pready is tied high and reads return the register. one item is in work at a time;
//  ready is high only in the idle state. measure: ready again after the sum,
//  luminance and min/max update states; a new measure is taken only in idle.
//  remap: the response follows the radix-4 restoring divider (9 steps for the
//  18-bit stretch numerator) and three passes of the one channel multiplier (a
//  product and a scale state per channel); the divider is skipped when max equals
//  min. a new remap is taken only once the last one has gone to the output register.
//  the response sits in an output register; the next item is taken while it waits,
//  and a later remap holds in its last state until that register is free.
//  reset (synchronous) clears the registers to lower 0, upper 100, min 100, max 0
//  and empties the output register.
module luma_contrast_stretch_unit (
   input  logic                             clock,
   input  logic                             reset,
   lcs_req_if.sink                          req_chan,
   lcs_rsp_if.source                        rsp_chan,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lcs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [lcs_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lcs_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import lcs_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_SUM     = 10'b00_0000_0010,
      ST_LUMA    = 10'b00_0000_0100,
      ST_UPDATE  = 10'b00_0000_1000,
      ST_SETUP   = 10'b00_0001_0000,
      ST_DIVIDE  = 10'b00_0010_0000,
      ST_PERCENT = 10'b00_0100_0000,
      ST_PRODUCT = 10'b00_1000_0000,
      ST_SCALE   = 10'b01_0000_0000,
      ST_EMIT    = 10'b10_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [PCT_W-1:0]   lower_ff, lower_in;
   logic [PCT_W-1:0]   upper_ff, upper_in;
   logic [LUMA_W-1:0]  min_ff, min_in;
   logic [LUMA_W-1:0]  max_ff, max_in;
   logic               cmd_ff, cmd_in;
   logic               first_ff, first_in;
   logic [PIXEL_W-1:0] pixel_ff, pixel_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [LUMA_W-1:0]  luma_ff, luma_in;
   logic [PCT_W-1:0]   lo_ff, lo_in;
   logic [LUMA_W-1:0]  den_ff, den_in;
   logic               neg_ff, neg_in;
   logic               equal_ff, equal_in;
   logic [NUM_W-1:0]   quot_ff, quot_in;
   logic [LUMA_W-1:0]  rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PCT_SAT_W-1:0] pct_ff, pct_in;
   chan_sel_type       chan_ff, chan_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [PIXEL_W-1:0] res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] out_rgb_ff, out_rgb_in;

   logic               req_xfer;
   logic               csr_write;
   logic [MULT_W-1:0]  luma_mult;
   logic [MULT_W-1:0]  scale_mult;
   logic [PCT_W-1:0]   lo_sel;
   logic [PCT_W-1:0]   diff;
   logic [LUMA_W-1:0]  min_base;
   logic [LUMA_W-1:0]  max_base;
   logic [NUM_W-1:0]   div_q;
   logic [LUMA_W-1:0]  div_r;
   logic [LUMA_W:0]    div_t;
   logic [PCT_EXT_W-1:0] pct_raw;
   logic [CHAN_W-1:0]  chan_val;
   logic [CHAN_W-1:0]  chan_out;

   assign req_xfer     = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_write    = psel && penable && pwrite && pready;
   assign pready       = 1'b1;
   assign prdata       = (paddr[CSR_ADDR_W-1] == REG_UPPER) ?
                         CSR_DATA_W'(upper_ff) : CSR_DATA_W'(lower_ff);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.out_rgb = out_rgb_ff;

   // constant reciprocal multiplies for the two divisions by 100
   assign luma_mult  = MULT_W'(sum_ff) * MULT_W'(DIV100_RECIP);
   assign scale_mult = MULT_W'(prod_ff[PCT_SAT_W-1:0]) * MULT_W'(DIV100_RECIP);

   always_comb begin
      unique case (chan_ff)
         CH_RED:   chan_val = pixel_ff[23:16];
         CH_GREEN: chan_val = pixel_ff[15:8];
         CH_BLUE:  chan_val = pixel_ff[7:0];
         default:  chan_val = pixel_ff[7:0];
      endcase
   end

   // two restoring division steps per cycle
   always_comb begin
      div_q = quot_ff;
      div_r = rem_ff;
      div_t = '0;
      for (int i = 0; i < 2; i++) begin
         div_t = {div_r, div_q[NUM_W-1]};
         div_q = {div_q[NUM_W-2:0], 1'b0};
         if (div_t >= {1'b0, den_ff}) begin
            div_t    = div_t - {1'b0, den_ff};
            div_q[0] = 1'b1;
         end
         div_r = div_t[LUMA_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      lower_in     = lower_ff;
      upper_in     = upper_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      cmd_in       = cmd_ff;
      first_in     = first_ff;
      pixel_in     = pixel_ff;
      sum_in       = sum_ff;
      luma_in      = luma_ff;
      lo_in        = lo_ff;
      den_in       = den_ff;
      neg_in       = neg_ff;
      equal_in     = equal_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      pct_in       = pct_ff;
      chan_in      = chan_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      out_rgb_in   = out_rgb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      lo_sel   = (lower_ff > upper_ff) ? upper_ff : lower_ff;
      diff     = upper_ff - lo_sel;
      min_base = first_ff ? MIN_LUMA_RESET : min_ff;
      max_base = first_ff ? MAX_LUMA_RESET : max_ff;
      pct_raw  = '0;
      chan_out = '0;

      if (csr_write) begin
         if (paddr[CSR_ADDR_W-1] == REG_UPPER) begin
            upper_in = pwdata[PCT_W-1:0];
         end else begin
            lower_in = pwdata[PCT_W-1:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cmd_in   = req_chan.cmd;
               first_in = req_chan.first_pixel;
               pixel_in = req_chan.pixel_rgb;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_in   = SUM_W'(pixel_ff[23:16]) * R_WEIGHT
                     + SUM_W'(pixel_ff[15:8]) * G_WEIGHT
                     + SUM_W'(pixel_ff[7:0]) * B_WEIGHT;
            state_in = ST_LUMA;
         end
         ST_LUMA: begin
            luma_in  = luma_mult[RECIP_SH +: LUMA_W];
            state_in = (cmd_ff == CMD_REMAP) ? ST_SETUP : ST_UPDATE;
         end
         ST_UPDATE: begin
            min_in   = (luma_ff < min_base) ? luma_ff : min_base;
            max_in   = (luma_ff > max_base) ? luma_ff : max_base;
            state_in = ST_IDLE;
         end
         ST_SETUP: begin
            lo_in    = lo_sel;
            quot_in  = NUM_W'(diff) * NUM_W'(luma_ff);
            rem_in   = '0;
            cnt_in   = '0;
            neg_in   = (max_ff < min_ff);
            equal_in = (max_ff == min_ff);
            den_in   = (max_ff < min_ff) ? (min_ff - max_ff) : (max_ff - min_ff);
            state_in = (max_ff == min_ff) ? ST_PERCENT : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            quot_in = div_q;
            rem_in  = div_r;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_PERCENT;
            end
         end
         ST_PERCENT: begin
            // quotient truncates toward zero, so a negative range subtracts it
            if (equal_ff) begin
               pct_raw = PCT_EXT_W'(luma_ff);
            end else if (neg_ff) begin
               pct_raw = PCT_EXT_W'(lo_ff) - PCT_EXT_W'(quot_ff);
            end else begin
               pct_raw = PCT_EXT_W'(lo_ff) + PCT_EXT_W'(quot_ff);
            end
            if (pct_raw[PCT_EXT_W-1]) begin
               pct_in = '0;
            end else if (pct_raw > PCT_EXT_W'(PCT_SAT)) begin
               pct_in = PCT_SAT;
            end else begin
               pct_in = pct_raw[PCT_SAT_W-1:0];
            end
            chan_in  = CH_RED;
            state_in = ST_PRODUCT;
         end
         ST_PRODUCT: begin
            prod_in  = PROD_W'(chan_val) * PROD_W'(pct_ff);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            chan_out = (prod_ff >= PROD_SAT) ? CHAN_MAX : scale_mult[RECIP_SH +: CHAN_W];
            res_in   = {res_ff[PIXEL_W-CHAN_W-1:0], chan_out};
            if (chan_ff == CH_BLUE) begin
               state_in = ST_EMIT;
            end else begin
               chan_in  = (chan_ff == CH_RED) ? CH_GREEN : CH_BLUE;
               state_in = ST_PRODUCT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               out_rgb_in   = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lower_ff     <= LOWER_RESET;
         upper_ff     <= UPPER_RESET;
         min_ff       <= MIN_LUMA_RESET;
         max_ff       <= MAX_LUMA_RESET;
         cnt_ff       <= '0;
         chan_ff      <= CH_RED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         cnt_ff       <= cnt_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      first_ff   <= first_in;
      pixel_ff   <= pixel_in;
      sum_ff     <= sum_in;
      luma_ff    <= luma_in;
      lo_ff      <= lo_in;
      den_ff     <= den_in;
      neg_ff     <= neg_in;
      equal_ff   <= equal_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      pct_ff     <= pct_in;
      prod_ff    <= prod_in;
      res_ff     <= res_in;
      out_rgb_ff <= out_rgb_in;
   end

`ifndef SYNTH
   a_div_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   a_pct_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRODUCT) |-> (pct_ff <= PCT_SAT))
      else $error("scale percentage above saturation bound");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside the emit state");

   a_div_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (cnt_ff <= DIV_LAST))
      else $error("divider step count overran");
`endif

endmodule

/* tb/luma_contrast_stretch_unit_tb.sv */
// luma_contrast_stretch_unit_tb: self-checking bench for the luma contrast stretch block
// drives measure and remap frames plus apb register settings, predicts every remapped pixel
// depends on lcs_pkg, the channel interfaces in lcs_channels.sv and luma_contrast_stretch_unit
`timescale 1ns / 1ps

module luma_contrast_stretch_unit_tb;
   import lcs_pkg::*;

   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 10;
   localparam int SETTLE_CYCLES   = 30;    // lets the last measure return to idle after every remap is back
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int MAX_FRAME       = 16;
   localparam int NUM_PHASES      = 8;
   localparam int PHASE_ITEMS     = 250;
   localparam int REPORT_LIMIT    = 10;

   typedef enum {RX_STEADY, RX_RANDOM, RX_SPARSE} rx_mode_type;
   typedef enum {PX_ANY, PX_DARK, PX_BRIGHT, PX_GRAY, PX_RAILS} px_style_type;

   // keeps the stretch statistics and registers, predicts each remapped pixel
   class stretch_scoreboard;
      int lower_pct;
      int upper_pct;
      int min_luma;
      int max_luma;
      logic [PIXEL_W-1:0] expected_rgb[$];
      int fails;
      int checked;
      int measured;
      int remapped;

      function void reset_state();
         lower_pct = int'(LOWER_RESET);
         upper_pct = int'(UPPER_RESET);
         min_luma  = int'(MIN_LUMA_RESET);
         max_luma  = int'(MAX_LUMA_RESET);
         expected_rgb.delete();
      endfunction

      function void set_reg(csr_index_type idx, int value);
         if (idx == REG_LOWER) begin
            lower_pct = value;
         end else begin
            upper_pct = value;
         end
      endfunction

      function void note_failure(string msg);
         fails++;
         if (fails <= REPORT_LIMIT) begin
            $display("%0t: mismatch: %s", $time, msg);
         end
      endfunction

      function int scaled(int chan, longint pct);
         longint v;
         v = (longint'(chan) * pct) / 100;
         if (v > longint'(CHAN_MAX)) begin
            v = longint'(CHAN_MAX);
         end
         return int'(v);
      endfunction

      function void note_pixel(cmd_type cmd, logic first, logic [PIXEL_W-1:0] rgb);
         int r;
         int g;
         int b;
         int luma;
         longint lo;
         longint hi;
         longint pct;
         longint span;
         r = int'(rgb[23:16]);
         g = int'(rgb[15:8]);
         b = int'(rgb[7:0]);
         luma = (r * 11 + g * 80 + b * 9) / 100;
         if (cmd == CMD_MEASURE) begin
            measured++;
            if (first) begin
               min_luma = int'(MIN_LUMA_RESET);
               max_luma = int'(MAX_LUMA_RESET);
            end
            if (luma < min_luma) begin
               min_luma = luma;
            end
            if (luma > max_luma) begin
               max_luma = luma;
            end
            return;
         end
         remapped++;
         lo = longint'(lower_pct);
         hi = longint'(upper_pct);
         if (lo > hi) begin
            lo = hi;
         end
         pct = longint'(luma);
         if (max_luma != min_luma) begin
            // span may be negative; division truncates toward zero
            span = longint'(max_luma) - longint'(min_luma);
            pct = lo + ((hi - lo) * longint'(luma)) / span;
         end
         if (pct < 0) begin
            pct = 0;
         end
         expected_rgb.push_back({8'(scaled(r, pct)), 8'(scaled(g, pct)), 8'(scaled(b, pct))});
      endfunction

      function void check_pixel(logic [PIXEL_W-1:0] actual);
         logic [PIXEL_W-1:0] want;
         if (expected_rgb.size() == 0) begin
            note_failure($sformatf("out_rgb %06h with no remap pending", actual));
            return;
         end
         want = expected_rgb.pop_front();
         checked++;
         if (actual !== want) begin
            note_failure($sformatf("out_rgb expected %06h actual %06h", want, actual));
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   lcs_req_if req_if();
   lcs_rsp_if rsp_if();

   stretch_scoreboard sb = new();

   int burst_left = 0;
   int items_sent = 0;
   int settings_used = 0;
   int idle_cycles = 0;
   bit activity;
   bit hold_off_pending = 1'b0;

   luma_contrast_stretch_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #HALF_PERIOD clock = ~clock;

   initial begin
      req_if.valid       = 1'b0;
      req_if.cmd         = CMD_MEASURE;
      req_if.first_pixel = 1'b0;
      req_if.pixel_rgb   = '0;
   end

   // transfer monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         activity = 1'b0;
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_pixel(rsp_if.out_rgb);
            activity = 1'b1;
         end
         if (req_if.valid && req_if.ready) begin
            sb.note_pixel(cmd_type'(req_if.cmd), req_if.first_pixel, req_if.pixel_rgb);
            activity = 1'b1;
         end
         if (psel) begin
            activity = 1'b1;
         end
         idle_cycles = activity ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d responses outstanding",
                     $time, idle_cycles, sb.expected_rgb.size());
            $display("[luma_contrast_stretch_unit] ERROR");
            $finish;
         end
      end
   end

   // response side: stretches of steady, random and sparse ready, plus one long hold-off
   initial begin
      rx_mode_type mode;
      int mode_left;
      mode = RX_STEADY;
      mode_left = 0;
      rsp_if.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(8, 80);
         end
         mode_left--;
         case (mode)
            RX_STEADY: rsp_if.ready <= 1'b1;
            RX_RANDOM: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            default:   rsp_if.ready <= (mode_left % 4 == 0);
         endcase
      end
   end

   task automatic send_pixel(cmd_type cmd, logic first, logic [PIXEL_W-1:0] rgb);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
      end
      req_if.valid       <= 1'b1;
      req_if.cmd         <= cmd;
      req_if.first_pixel <= first;
      req_if.pixel_rgb   <= rgb;
      do @(posedge clock); while (!req_if.ready);
      burst_left--;
      items_sent++;
   endtask

   // drop valid, let every remap come back and the last measure finish
   task automatic settle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (sb.expected_rgb.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(int'(idx) * 4);
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_reg(idx, value);
      // read back through a second setup and access
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_W'(value)) begin
         sb.note_failure($sformatf("register %s read expected %0d actual %0d",
                                   idx.name(), value, prdata));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      // bus returns to idle before the next access
      @(posedge clock);
   endtask

   task automatic set_stretch(int lower, int upper);
      write_reg(REG_LOWER, lower);
      write_reg(REG_UPPER, upper);
      settings_used++;
   endtask

   function automatic logic [PIXEL_W-1:0] make_pixel(px_style_type style);
      logic [CHAN_W-1:0] v;
      case (style)
         PX_DARK:   return {8'($urandom_range(0, 70)), 8'($urandom_range(0, 70)),
                            8'($urandom_range(0, 70))};
         PX_BRIGHT: return {8'($urandom_range(150, 255)), 8'($urandom_range(150, 255)),
                            8'($urandom_range(150, 255))};
         PX_GRAY: begin
            v = 8'($urandom_range(0, 255));
            return {v, v, v};
         end
         PX_RAILS:  return {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
         default:   return PIXEL_W'($urandom);
      endcase
   endfunction

   // measure pass then remap pass over the same pixels; now and then a broken frame
   task automatic run_frame();
      logic [PIXEL_W-1:0] frame_px[MAX_FRAME];
      int n;
      int remap_n;
      px_style_type style;
      bit broken;
      n = ($urandom_range(0, 9) == 0) ? MAX_FRAME : $urandom_range(1, 6);
      style = px_style_type'($urandom_range(0, 4));
      broken = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < n; i++) begin
         frame_px[i] = make_pixel(style);
      end
      for (int i = 0; i < n; i++) begin
         send_pixel(CMD_MEASURE, (i == 0) && !broken, frame_px[i]);
      end
      remap_n = broken ? $urandom_range(0, n) : n;
      for (int i = 0; i < remap_n; i++) begin
         send_pixel(CMD_REMAP, 1'($urandom), frame_px[i]);
      end
   endtask

   initial begin
      int lower_set[NUM_PHASES];
      int upper_set[NUM_PHASES];
      int target;
      lower_set = '{0, 0, 1023, 0, 1023, -1, 20, -1};
      upper_set = '{100, 0, 1023, 1023, 0, -1, 200, -1};
      sb.reset_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings; remap before any measure sees a negative span
      send_pixel(CMD_REMAP, 1'b0, 24'h808080);
      send_pixel(CMD_REMAP, 1'b0, 24'h000000);
      // all luminances above the start minimum keep it there
      send_pixel(CMD_MEASURE, 1'b1, 24'hffffff);
      send_pixel(CMD_MEASURE, 1'b0, 24'hc8c8c8);
      // first flag on a remap is ignored; white overflows every channel
      send_pixel(CMD_REMAP, 1'b1, 24'hffffff);
      send_pixel(CMD_REMAP, 1'b0, 24'h000000);
      send_pixel(CMD_REMAP, 1'b0, 24'h123456);
      // single-pixel frames: flat statistics, luminance used as the percentage
      send_pixel(CMD_MEASURE, 1'b1, 24'h000000);
      send_pixel(CMD_REMAP, 1'b0, 24'hff00ff);
      send_pixel(CMD_MEASURE, 1'b1, 24'h0000ff);
      send_pixel(CMD_REMAP, 1'b0, 24'hff0000);
      settle();

      // lower above upper clamps to upper
      set_stretch(1023, 0);
      send_pixel(CMD_MEASURE, 1'b1, 24'h000000);
      send_pixel(CMD_MEASURE, 1'b0, 24'hffffff);
      send_pixel(CMD_REMAP, 1'b0, 24'hffffff);
      send_pixel(CMD_REMAP, 1'b0, 24'h00ff00);
      settle();

      set_stretch(1023, 1023);
      send_pixel(CMD_REMAP, 1'b0, 24'h010101);
      send_pixel(CMD_REMAP, 1'b0, 24'hffffff);
      send_pixel(CMD_REMAP, 1'b0, 24'h0000ff);
      settle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         set_stretch((lower_set[p] < 0) ? $urandom_range(0, 1023) : lower_set[p],
                     (upper_set[p] < 0) ? $urandom_range(0, 1023) : upper_set[p]);
         if (p == 3) begin
            hold_off_pending = 1'b1;
         end
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            if ($urandom_range(0, 9) < 8) begin
               run_frame();
            end else begin
               repeat ($urandom_range(1, 4)) begin
                  send_pixel(cmd_type'($urandom_range(0, 1)), 1'($urandom),
                             PIXEL_W'($urandom));
               end
            end
         end
         settle();
      end

      if (sb.expected_rgb.size() != 0) begin
         sb.note_failure($sformatf("%0d remapped pixels never returned",
                                   sb.expected_rgb.size()));
      end
      $display("run covered %0d measure and %0d remap transfers over %0d register settings",
               sb.measured, sb.remapped, settings_used);
      $display("%0d remapped pixels checked, %0d failures", sb.checked, sb.fails);
      if (sb.fails == 0) begin
         $display("[luma_contrast_stretch_unit] OK");
      end else begin
         $display("[luma_contrast_stretch_unit] ERROR");
      end
      $finish;
   end

endmodule
